// ===== hdl/ufr_pkg.sv =====
`default_nettype none

package ufr_pkg;

    // Field widths
    localparam int DATA_W = 8;
    localparam int LEN_W  = 7;
    localparam int KIND_W = 2;

    // Default payload capacity
    localparam int MAX_PAYLOAD_DEF = 64;

    // Command queue depth between the parser and the drainer
    localparam int CMD_FIFO_DEPTH = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_XFER   = 2'd3;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_ACK_BYTE   = 2'd1;
    localparam logic [1:0] REG_NACK_BYTE  = 2'd2;

    // Register reset values
    localparam logic [DATA_W-1:0] START_BYTE_RST = 8'd239;
    localparam logic [DATA_W-1:0] ACK_BYTE_RST   = 8'd6;
    localparam logic [DATA_W-1:0] NACK_BYTE_RST  = 8'd21;

    // One queued command: a single result, or a drain of the payload store
    typedef struct packed {
        logic              drain;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    // Payload store write port
    typedef struct packed {
        logic              we;
        logic [LEN_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_mem_wr;

endpackage

`default_nettype wire

// ===== hdl/ufr_rx_if.sv =====
`default_nettype none

interface ufr_rx_if;
    logic                       valid;
    logic                       ready;
    logic [ufr_pkg::DATA_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/ufr_res_if.sv =====
`default_nettype none

interface ufr_res_if;
    logic                       valid;
    logic                       ready;
    logic [ufr_pkg::KIND_W-1:0] kind;
    logic [ufr_pkg::DATA_W-1:0] out_byte;
    logic [ufr_pkg::LEN_W-1:0]  payload_length;
    logic                       last;

    modport source (output valid, output kind, output out_byte, output payload_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input payload_length,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/uart_frame_receiver.sv =====
// Path: a reply passes the command queue, then the output register; a payload drain
//   passes the command queue, the registered store read, then the output register.
// Throughput: one received byte per cycle unless the command queue is full; a drain
//   reads the store once per byte; next-frame payload bytes wait for it to end.
// Reset: synchronous, active low; returns to waiting for a start byte, restores the
//   register defaults and marks the next good frame as an update request.
`default_nettype none

module uart_frame_receiver #(
    parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    ufr_rx_if.sink                         i_rx,
    ufr_res_if.source                      o_res,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [ufr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire [ufr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ufr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [ufr_pkg::DATA_W-1:0] r_start_byte;
    logic [ufr_pkg::DATA_W-1:0] r_ack_byte;
    logic [ufr_pkg::DATA_W-1:0] r_nack_byte;
    logic [ufr_pkg::DATA_W-1:0] w_rd_byte;
    logic [1:0]                 w_reg_idx;
    logic                       w_cfg_write;

    logic                       w_push;
    logic                       w_pop;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_drain_done;
    ufr_pkg::t_cmd              w_cmd_in;
    ufr_pkg::t_cmd              w_cmd_out;
    ufr_pkg::t_mem_wr           w_mem_wr;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[3:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= ufr_pkg::START_BYTE_RST;
            r_ack_byte   <= ufr_pkg::ACK_BYTE_RST;
            r_nack_byte  <= ufr_pkg::NACK_BYTE_RST;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                ufr_pkg::REG_START_BYTE: r_start_byte <= pwdata[ufr_pkg::DATA_W-1:0];
                ufr_pkg::REG_ACK_BYTE:   r_ack_byte   <= pwdata[ufr_pkg::DATA_W-1:0];
                ufr_pkg::REG_NACK_BYTE:  r_nack_byte  <= pwdata[ufr_pkg::DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_reg_idx)
            ufr_pkg::REG_START_BYTE: w_rd_byte = r_start_byte;
            ufr_pkg::REG_ACK_BYTE:   w_rd_byte = r_ack_byte;
            ufr_pkg::REG_NACK_BYTE:  w_rd_byte = r_nack_byte;
            default:                 w_rd_byte = '0;
        endcase
    end

    assign prdata = {{(ufr_pkg::APB_DATA_W - ufr_pkg::DATA_W){1'b0}}, w_rd_byte};

    ufr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_start_byte (r_start_byte),
        .i_ack_byte   (r_ack_byte),
        .i_nack_byte  (r_nack_byte),
        .i_fifo_full  (w_full),
        .i_drain_done (w_drain_done),
        .o_push       (w_push),
        .o_cmd        (w_cmd_in),
        .o_mem_wr     (w_mem_wr)
    );

    ufr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    ufr_drainer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_drainer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_cmd        (w_cmd_out),
        .o_pop        (w_pop),
        .i_mem_wr     (w_mem_wr),
        .o_drain_done (w_drain_done),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

// ===== hdl/ufr_parser.sv =====
`default_nettype none

module ufr_parser #(
    parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    ufr_rx_if.sink                     i_rx,
    input  wire [ufr_pkg::DATA_W-1:0]  i_start_byte,
    input  wire [ufr_pkg::DATA_W-1:0]  i_ack_byte,
    input  wire [ufr_pkg::DATA_W-1:0]  i_nack_byte,
    input  wire                        i_fifo_full,
    input  wire                        i_drain_done,
    output logic                       o_push,
    output ufr_pkg::t_cmd              o_cmd,
    output ufr_pkg::t_mem_wr           o_mem_wr
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    localparam logic [ufr_pkg::DATA_W-1:0] MaxLenByte =
        MAX_PAYLOAD[ufr_pkg::DATA_W-1:0];

    logic [1:0]                 r_phase, n_phase;
    logic [ufr_pkg::LEN_W-1:0]  r_len, n_len;
    logic [ufr_pkg::LEN_W-1:0]  r_pos, n_pos;
    logic [ufr_pkg::DATA_W-1:0] r_chk, n_chk;
    logic                       r_first, n_first;
    logic                       r_drain_open;
    logic                       w_accept;
    logic [ufr_pkg::LEN_W-1:0]  w_pos_inc;

    // Stall payload bytes while the store is still being drained, and all bytes while the queue is full
    assign i_rx.ready = !i_fifo_full && !((r_phase == PH_DATA) && r_drain_open);
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_pos_inc  = r_pos + ufr_pkg::LEN_W'(1);

    // Classify the byte against the current phase
    always_comb begin
        n_phase       = r_phase;
        n_len         = r_len;
        n_pos         = r_pos;
        n_chk         = r_chk;
        n_first       = r_first;
        o_push        = 1'b0;
        o_cmd.drain   = 1'b0;
        o_cmd.kind    = ufr_pkg::KIND_ACK;
        o_cmd.data    = i_ack_byte;
        o_cmd.len     = '0;
        o_mem_wr.we   = 1'b0;
        o_mem_wr.addr = r_pos;
        o_mem_wr.data = i_rx.rx_byte;
        case (r_phase)
            PH_START: begin
                o_push = w_accept;
                if (i_rx.rx_byte == i_start_byte) begin
                    n_phase = PH_LEN;
                end else begin
                    o_cmd.kind = ufr_pkg::KIND_NACK;
                    o_cmd.data = i_nack_byte;
                end
            end
            PH_LEN: begin
                o_push = w_accept;
                if (i_rx.rx_byte > MaxLenByte) begin
                    n_phase    = PH_START;
                    o_cmd.kind = ufr_pkg::KIND_NACK;
                    o_cmd.data = i_nack_byte;
                end else begin
                    n_len   = i_rx.rx_byte[ufr_pkg::LEN_W-1:0];
                    n_pos   = '0;
                    n_chk   = i_rx.rx_byte;
                    n_phase = (i_rx.rx_byte == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                o_mem_wr.we = w_accept;
                n_chk       = r_chk ^ i_rx.rx_byte;
                n_pos       = w_pos_inc;
                if (w_pos_inc == r_len) begin
                    o_push  = w_accept;
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_push  = w_accept;
                n_phase = PH_START;
                if (i_rx.rx_byte != r_chk) begin
                    o_cmd.kind = ufr_pkg::KIND_NACK;
                    o_cmd.data = i_nack_byte;
                end else begin
                    o_cmd.kind  = r_first ? ufr_pkg::KIND_UPDATE : ufr_pkg::KIND_XFER;
                    o_cmd.data  = '0;
                    n_first     = 1'b0;
                    o_cmd.drain = (r_len != '0);
                    o_cmd.len   = r_len;
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
    end

    // Advance control state on each accepted byte and track whether a drain is open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_first      <= 1'b1;
            r_drain_open <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_first <= n_first;
            end
            if (o_push && o_cmd.drain) begin
                r_drain_open <= 1'b1;
            end else if (i_drain_done) begin
                r_drain_open <= 1'b0;
            end
        end
    end

    // Hold frame bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len <= n_len;
            r_pos <= n_pos;
            r_chk <= n_chk;
        end
    end

    a_no_write_during_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr.we |-> !r_drain_open)
        else $error("payload written while the store is being drained");

    a_drain_not_reopened: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.drain) |-> !r_drain_open)
        else $error("second drain queued before the first finished");

endmodule

`default_nettype wire

// ===== hdl/ufr_cmd_fifo.sv =====
`default_nettype none

module ufr_cmd_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire ufr_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output ufr_pkg::t_cmd       o_cmd
);

    localparam int Depth = ufr_pkg::CMD_FIFO_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    ufr_pkg::t_cmd   r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store incoming commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== hdl/ufr_drainer.sv =====
`default_nettype none

module ufr_drainer #(
    parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_empty,
    input  wire ufr_pkg::t_cmd     i_cmd,
    output logic                   o_pop,
    input  wire ufr_pkg::t_mem_wr  i_mem_wr,
    output logic                   o_drain_done,
    ufr_res_if.source              o_res
);

    localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [ufr_pkg::DATA_W-1:0] r_mem [MAX_PAYLOAD];
    logic [ufr_pkg::DATA_W-1:0] r_mem_q;

    logic [1:0]                 r_state, n_state;
    logic [ufr_pkg::LEN_W-1:0]  r_idx, n_idx;
    logic [ufr_pkg::LEN_W-1:0]  r_len, n_len;
    logic [ufr_pkg::KIND_W-1:0] r_kind, n_kind;

    logic                       r_out_valid;
    logic [ufr_pkg::KIND_W-1:0] r_out_kind, n_out_kind;
    logic [ufr_pkg::DATA_W-1:0] r_out_byte, n_out_byte;
    logic [ufr_pkg::LEN_W-1:0]  r_out_len, n_out_len;
    logic                       r_out_last, n_out_last;

    logic                       w_slot_free;
    logic                       w_load;
    logic                       w_last_byte;
    logic [ufr_pkg::LEN_W-1:0]  w_idx_inc;

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_idx_inc   = r_idx + ufr_pkg::LEN_W'(1);
    assign w_last_byte = (w_idx_inc == r_len);

    // Payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.we) begin
            r_mem[i_mem_wr.addr[AddrW-1:0]] <= i_mem_wr.data;
        end
        r_mem_q <= r_mem[r_idx[AddrW-1:0]];
    end

    // Sequence replies and payload drains
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_len        = r_len;
        n_kind       = r_kind;
        o_pop        = 1'b0;
        o_drain_done = 1'b0;
        w_load       = 1'b0;
        n_out_kind   = i_cmd.kind;
        n_out_byte   = i_cmd.data;
        n_out_len    = i_cmd.len;
        n_out_last   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.drain) begin
                        o_pop   = 1'b1;
                        n_kind  = i_cmd.kind;
                        n_len   = i_cmd.len;
                        n_idx   = '0;
                        n_state = ST_READ;
                    end else if (w_slot_free) begin
                        o_pop  = 1'b1;
                        w_load = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_out_kind = r_kind;
                n_out_byte = r_mem_q;
                n_out_len  = r_len;
                n_out_last = w_last_byte;
                if (w_slot_free) begin
                    w_load = 1'b1;
                    if (w_last_byte) begin
                        o_drain_done = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_idx   = w_idx_inc;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Drain bookkeeping and output payload
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_len  <= n_len;
        r_kind <= n_kind;
        if (w_load) begin
            r_out_kind <= n_out_kind;
            r_out_byte <= n_out_byte;
            r_out_len  <= n_out_len;
            r_out_last <= n_out_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out_kind;
    assign o_res.out_byte       = r_out_byte;
    assign o_res.payload_length = r_out_len;
    assign o_res.last           = r_out_last;

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx < r_len))
        else $error("drain index past the frame length");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN      = ufr_pkg::MAX_PAYLOAD_DEF;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_WAIT  = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 180;
    localparam int MAX_REPORTS  = 10;
    // Index past the last register, writes to it must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        PARSE_START,
        PARSE_LEN,
        PARSE_DATA,
        PARSE_CHECK
    } t_parse_phase;

    typedef struct packed {
        logic [ufr_pkg::KIND_W-1:0] kind;
        logic [ufr_pkg::DATA_W-1:0] out_byte;
        logic [ufr_pkg::LEN_W-1:0]  payload_length;
        logic                       last;
    } t_frame_result;

    // Frame parser prediction plus the queue of replies and requests still owed
    class t_frame_scoreboard;
        logic [ufr_pkg::DATA_W-1:0] start_code;
        logic [ufr_pkg::DATA_W-1:0] ack_code;
        logic [ufr_pkg::DATA_W-1:0] nack_code;
        t_parse_phase               phase;
        logic [ufr_pkg::LEN_W-1:0]  want_len;
        logic [ufr_pkg::LEN_W-1:0]  pos;
        logic [ufr_pkg::DATA_W-1:0] xor_sum;
        logic [ufr_pkg::DATA_W-1:0] payload [MAX_LEN];
        bit                         update_pending;
        t_frame_result              owed_q [$];
        int                         mismatches;
        int                         results_checked;
        int                         frames_good;
        int                         frames_bad;
        int                         nacks;

        function new();
            start_code      = ufr_pkg::START_BYTE_RST;
            ack_code        = ufr_pkg::ACK_BYTE_RST;
            nack_code       = ufr_pkg::NACK_BYTE_RST;
            phase           = PARSE_START;
            want_len        = '0;
            pos             = '0;
            xor_sum         = '0;
            update_pending  = 1'b1;
            mismatches      = 0;
            results_checked = 0;
            frames_good     = 0;
            frames_bad      = 0;
            nacks           = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [ufr_pkg::DATA_W-1:0] value);
            case (idx)
                ufr_pkg::REG_START_BYTE: start_code = value;
                ufr_pkg::REG_ACK_BYTE:   ack_code = value;
                ufr_pkg::REG_NACK_BYTE:  nack_code = value;
                default: ;
            endcase
        endfunction

        function void owe(logic [ufr_pkg::KIND_W-1:0] kind, logic [ufr_pkg::DATA_W-1:0] code,
                          logic [ufr_pkg::LEN_W-1:0] len, logic last);
            t_frame_result r;
            r.kind           = kind;
            r.out_byte       = code;
            r.payload_length = len;
            r.last           = last;
            owed_q.push_back(r);
        endfunction

        // Advance the parser by one received byte
        function void note_rx_byte(logic [ufr_pkg::DATA_W-1:0] b);
            logic [ufr_pkg::KIND_W-1:0] req_kind;
            int                         i;
            case (phase)
                PARSE_START: begin
                    if (b == start_code) begin
                        phase = PARSE_LEN;
                        owe(ufr_pkg::KIND_ACK, ack_code, '0, 1'b1);
                    end else begin
                        owe(ufr_pkg::KIND_NACK, nack_code, '0, 1'b1);
                        nacks++;
                    end
                end
                PARSE_LEN: begin
                    if (b > MAX_LEN) begin
                        phase = PARSE_START;
                        owe(ufr_pkg::KIND_NACK, nack_code, '0, 1'b1);
                        nacks++;
                    end else begin
                        want_len = b[ufr_pkg::LEN_W-1:0];
                        pos      = '0;
                        xor_sum  = b;
                        phase    = (b == 0) ? PARSE_CHECK : PARSE_DATA;
                        owe(ufr_pkg::KIND_ACK, ack_code, '0, 1'b1);
                    end
                end
                PARSE_DATA: begin
                    payload[pos] = b;
                    xor_sum      = xor_sum ^ b;
                    pos          = pos + ufr_pkg::LEN_W'(1);
                    if (pos >= want_len) begin
                        phase = PARSE_CHECK;
                        owe(ufr_pkg::KIND_ACK, ack_code, '0, 1'b1);
                    end
                end
                default: begin
                    phase = PARSE_START;
                    if (b != xor_sum) begin
                        owe(ufr_pkg::KIND_NACK, nack_code, '0, 1'b1);
                        nacks++;
                        frames_bad++;
                    end else begin
                        req_kind       = update_pending ? ufr_pkg::KIND_UPDATE
                                                        : ufr_pkg::KIND_XFER;
                        update_pending = 1'b0;
                        frames_good++;
                        if (want_len == 0) begin
                            owe(req_kind, '0, '0, 1'b1);
                        end else begin
                            for (i = 0; i < want_len; i++) begin
                                owe(req_kind, payload[i], want_len, (i + 1 == want_len));
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void report(string what, t_frame_result exp, t_frame_result got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t %s: expected kind %0d byte %02h len %0d last %0d",
                         $time, what, exp.kind, exp.out_byte, exp.payload_length, exp.last);
                $display("    got kind %0d byte %02h len %0d last %0d",
                         got.kind, got.out_byte, got.payload_length, got.last);
            end
        endfunction

        // Compare one delivered transaction with the oldest owed result
        function void check_result(t_frame_result got);
            t_frame_result exp;
            results_checked++;
            if (owed_q.size() == 0) begin
                exp = '0;
                report("result with nothing owed", exp, got);
            end else begin
                exp = owed_q.pop_front();
                if (got.kind !== exp.kind || got.out_byte !== exp.out_byte ||
                    got.payload_length !== exp.payload_length || got.last !== exp.last) begin
                    report("wrong result", exp, got);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ufr_pkg::APB_ADDR_W-1:0] paddr;
    logic [ufr_pkg::APB_DATA_W-1:0] pwdata;
    logic [ufr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    ufr_rx_if  rx_ch ();
    ufr_res_if res_ch ();

    t_frame_scoreboard sb;

    int bytes_sent  = 0;
    int cycle_count = 0;
    bit steady      = 1'b0;
    bit hold_res    = 1'b0;

    uart_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("uart_frame_receiver: mismatch");
            $finish;
        end
    end

    // Setup cycle, access cycle, register takes the value at the access edge
    task automatic apb_write(logic [1:0] idx, logic [ufr_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(ufr_pkg::APB_DATA_W-ufr_pkg::DATA_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(idx, value);
    endtask

    task automatic set_codes(logic [ufr_pkg::DATA_W-1:0] start_v,
                             logic [ufr_pkg::DATA_W-1:0] ack_v,
                             logic [ufr_pkg::DATA_W-1:0] nack_v);
        apb_write(ufr_pkg::REG_START_BYTE, start_v);
        apb_write(ufr_pkg::REG_ACK_BYTE, ack_v);
        apb_write(ufr_pkg::REG_NACK_BYTE, nack_v);
    endtask

    // Offer one byte after a random gap (none while steady or holding results), hold it until the transaction completes
    task automatic send_byte(logic [ufr_pkg::DATA_W-1:0] b);
        int gap;
        gap = (steady || hold_res) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(int len, bit good_check);
        logic [ufr_pkg::DATA_W-1:0] chk;
        logic [ufr_pkg::DATA_W-1:0] b;
        chk = len[ufr_pkg::DATA_W-1:0];
        send_byte(sb.start_code);
        send_byte(len[ufr_pkg::DATA_W-1:0]);
        repeat (len) begin
            b   = 8'($urandom_range(0, 255));
            chk = chk ^ b;
            send_byte(b);
        end
        if (!good_check) begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        send_byte(chk);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 0;
        end else if (r == 1) begin
            return MAX_LEN;
        end else if (r == 2) begin
            return $urandom_range(9, MAX_LEN);
        end
        return $urandom_range(1, 8);
    endfunction

    // Mostly well-formed frames, some noise, oversize lengths and cut-off frames
    task automatic send_random_traffic(int budget);
        int target;
        int pick;
        int len;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(pick_len(), $urandom_range(0, 6) != 0);
            end else if (pick < 80) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                send_byte(sb.start_code);
                send_byte(8'($urandom_range(MAX_LEN + 1, 255)));
            end else if (pick < 94) begin
                len = $urandom_range(2, 8);
                send_byte(sb.start_code);
                send_byte(len[ufr_pkg::DATA_W-1:0]);
                repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(sb.start_code ^ 8'($urandom_range(1, 255)));
            end
        end
        steady = 1'b0;
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus the long hold-off when requested
    initial begin
        int            stall;
        t_frame_result got;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0 || hold_res) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_res) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            got.kind           = res_ch.kind;
            got.out_byte       = res_ch.out_byte;
            got.payload_length = res_ch.payload_length;
            got.last           = res_ch.last;
            sb.check_result(got);
        end
    end

    // Hold off the result side for a long stretch so the input backs up
    initial begin
        wait (bytes_sent >= HOLD_AFTER);
        @(posedge i_clk);
        hold_res <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_res <= 1'b0;
    end

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Write to the unused index must change nothing
        apb_write(REG_SPARE, 8'h55);

        // Directed: wrong start, empty first frame, oversize lengths, bad and good checks
        send_byte(8'h00);
        send_frame(0, 1'b1);
        send_byte(sb.start_code);
        send_byte(8'(MAX_LEN + 1));
        send_byte(sb.start_code);
        send_byte(8'hFF);
        send_byte(sb.start_code);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(sb.start_code);
        send_byte(8'h02);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hFD);
        send_byte(sb.start_code);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);

        send_random_traffic(100);
        settle();

        set_codes(8'h00, 8'hFF, 8'h00);
        send_random_traffic(110);
        settle();

        set_codes(8'hFF, 8'h00, 8'hFF);
        send_random_traffic(110);
        settle();

        set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        send_random_traffic(110);
        settle();

        $display("Sent %0d bytes over four register settings, checked %0d results",
                 bytes_sent, sb.results_checked);
        $display("Frames passed %0d, frames failed check %0d, nack replies %0d",
                 sb.frames_good, sb.frames_bad, sb.nacks);
        if (sb.mismatches == 0) begin
            $display("uart_frame_receiver: match");
        end else begin
            $display("uart_frame_receiver: mismatch");
        end
        $finish;
    end

endmodule
